FILE: src/ufold_pkg.sv
// shared types, constants and the fold code table for the utf-8 diacritic folder
// no dependencies
package ufold_pkg;

  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // result of looking up a lead/trail pair
  typedef struct packed {
    logic       hit;
    logic       two;
    logic [7:0] rep0;
    logic [7:0] rep1;
  } fold_t;

  // everything one accepted beat produces
  typedef struct packed {
    logic      hit;
    logic [1:0] n_res;
    out_beat_t res0;
    out_beat_t res1;
    logic [7:0] held_byte;
    logic      held_valid;
  } step_t;

  function automatic fold_t fold_lookup(logic [7:0] lead, logic [7:0] trail);
    fold_t f;
    f.hit  = 1'b1;
    f.two  = 1'b0;
    f.rep0 = 8'h00;
    f.rep1 = 8'h00;
    case ({lead, trail})
      16'hC3A4, 16'hC3A0, 16'hC3A2, 16'hC485:           f.rep0 = "a";
      16'hC3B6, 16'hC3B4, 16'hC3B2, 16'hC3B3:           f.rep0 = "o";
      16'hC3BC, 16'hC3B9, 16'hC3BB:                     f.rep0 = "u";
      16'hC384, 16'hC380, 16'hC382, 16'hC484:           f.rep0 = "A";
      16'hC396, 16'hC394, 16'hC392, 16'hC393:           f.rep0 = "O";
      16'hC39C, 16'hC399, 16'hC39B:                     f.rep0 = "U";
      16'hC3A9, 16'hC3A8, 16'hC3AA, 16'hC3AB, 16'hC499: f.rep0 = "e";
      16'hC3A7, 16'hC487:                               f.rep0 = "c";
      16'hC3AE, 16'hC3AF, 16'hC3AC:                     f.rep0 = "i";
      16'hC389, 16'hC388, 16'hC38A, 16'hC38B, 16'hC498: f.rep0 = "E";
      16'hC387, 16'hC486:                               f.rep0 = "C";
      16'hC38E, 16'hC38F, 16'hC38C:                     f.rep0 = "I";
      16'hC582:                                         f.rep0 = "l";
      16'hC584:                                         f.rep0 = "n";
      16'hC59B:                                         f.rep0 = "s";
      16'hC5BA, 16'hC5BC:                               f.rep0 = "z";
      16'hC581:                                         f.rep0 = "L";
      16'hC583:                                         f.rep0 = "N";
      16'hC59A:                                         f.rep0 = "S";
      16'hC5B9, 16'hC5BB:                               f.rep0 = "Z";
      16'hC39F: begin
        f.rep0 = "s";
        f.rep1 = "s";
        f.two  = 1'b1;
      end
      default:                                          f.hit  = 1'b0;
    endcase
    return f;
  endfunction

endpackage

FILE: src/ufold_match.sv
// pair matcher: decides the results and next pending byte for one beat
// depends on ufold_pkg
module ufold_match (
  input  logic [7:0]          held_byte_i,
  input  logic                held_valid_i,
  input  ufold_pkg::in_beat_t beat_i,
  output ufold_pkg::step_t    step_o
);

  ufold_pkg::fold_t fold;

  assign fold = ufold_pkg::fold_lookup(held_byte_i, beat_i.in_byte);

  always_comb begin
    step_o                     = '0;
    step_o.res0.out_byte       = beat_i.in_byte;
    step_o.res1.out_byte       = beat_i.in_byte;
    step_o.held_byte           = beat_i.in_byte;
    if (held_valid_i && fold.hit) begin
      // folded pair, pending byte consumed
      step_o.hit               = 1'b1;
      step_o.res0.out_byte     = fold.rep0;
      step_o.res1.out_byte     = fold.rep1;
      step_o.res0.out_last     = beat_i.in_last & ~fold.two;
      step_o.res1.out_last     = beat_i.in_last;
      step_o.n_res             = fold.two ? 2'd2 : 2'd1;
      step_o.held_byte         = 8'h00;
    end else if (held_valid_i) begin
      step_o.res0.out_byte     = held_byte_i;
      step_o.res1.out_last     = 1'b1;
      if (beat_i.in_last) begin
        step_o.n_res           = 2'd2;
        step_o.held_byte       = 8'h00;
      end else begin
        step_o.n_res           = 2'd1;
        step_o.held_valid      = 1'b1;
      end
    end else if (beat_i.in_last) begin
      step_o.res0.out_last     = 1'b1;
      step_o.n_res             = 2'd1;
      step_o.held_byte         = 8'h00;
    end else begin
      step_o.held_valid        = 1'b1;
    end
  end

endmodule

FILE: src/ufold_outq.sv
// result queue: takes up to two beats per cycle, delivers one per cycle while the output is not stalled
// depends on ufold_pkg
module ufold_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_n_i,
  input  ufold_pkg::out_beat_t                push0_i,
  input  ufold_pkg::out_beat_t                push1_i,
  output logic [ufold_pkg::OutqCntW-1:0]      count_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ufold_pkg::out_beat_t                out_data_o
);

  ufold_pkg::out_beat_t                 mem_q [ufold_pkg::OutqDepth];
  logic [ufold_pkg::OutqPtrW-1:0]       wr_q, wr_d, wr_nxt;
  logic [ufold_pkg::OutqPtrW-1:0]       rd_q, rd_d;
  logic [ufold_pkg::OutqCntW-1:0]       cnt_q, cnt_d;
  logic                                 pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign wr_nxt      = wr_q + 1'b1;
  assign wr_d        = wr_q + ufold_pkg::OutqPtrW'(push_n_i);
  assign rd_d        = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d       = cnt_q + ufold_pkg::OutqCntW'(push_n_i)
                     - ufold_pkg::OutqCntW'(pop);
  assign count_o     = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ufold_pkg::OutqCntW'(ufold_pkg::OutqDepth))
    else $error("result queue overfilled");

  // below full the pointer gap wraps exactly like the count
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != ufold_pkg::OutqCntW'(ufold_pkg::OutqDepth)) |->
    ((wr_q - rd_q) == cnt_q[ufold_pkg::OutqPtrW-1:0]))
    else $error("queue pointers disagree with count");

  // a stalled result beat stays offered and unchanged
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

FILE: src/utf8_diacritic_folder.sv
// order: each accepted input beat writes its result beats into the result queue, which offers them in order
// throughput: one input beat per cycle while the input is not stalled; a sharp s or a flush on a last beat makes
//   two result beats, drained one per cycle while the output is not stalled, from a four-entry result queue
// input stalls while the queue holds more than two beats
// reset: asynchronous, clears the pending byte and empties the result queue
// depends on ufold_pkg, ufold_match, ufold_outq
module utf8_diacritic_folder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ufold_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ufold_pkg::out_beat_t out_data_o
);

  // pending byte of a possible two-byte code
  logic [7:0]                       held_byte_q, held_byte_d;
  logic                             held_valid_q, held_valid_d;
  ufold_pkg::step_t                 step;
  logic                             accept;
  logic [1:0]                       push_n;
  logic [ufold_pkg::OutqCntW-1:0]   q_count;

  // room for two more beats is required before a beat is taken
  assign in_stall_o = q_count > ufold_pkg::OutqCntW'(ufold_pkg::OutqDepth - 2);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_n     = accept ? step.n_res : 2'd0;

  // lookup and result selection for the incoming beat
  ufold_match u_match (
    .held_byte_i  (held_byte_q),
    .held_valid_i (held_valid_q),
    .beat_i       (in_data_i),
    .step_o       (step)
  );

  // pending byte only moves on an accepted beat
  assign held_byte_d  = accept ? step.held_byte  : held_byte_q;
  assign held_valid_d = accept ? step.held_valid : held_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= 8'h00;
      held_valid_q <= 1'b0;
    end else begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
    end
  end

  // result queue doubles as the output register
  ufold_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (step.res0),
    .push1_i     (step.res1),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a last beat always leaves nothing pending
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.in_last) |=> !held_valid_q)
    else $error("pending byte survived end of text");

  // a folded pair consumes the pending byte
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step.hit) |=> (!held_valid_q && held_byte_q == 8'h00))
    else $error("pending byte kept after fold");

  // a beat with no fold and no end of text is held
  a_miss_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !step.hit && !in_data_i.in_last) |=>
    (held_valid_q && held_byte_q == $past(in_data_i.in_byte)))
    else $error("unmatched byte not held");

  // idle cycles do not disturb the pending byte
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(held_valid_q) && $stable(held_byte_q)))
    else $error("pending byte changed without a beat");

endmodule
